// ----- hdl/frcm_pkg.sv -----
package frcm_pkg;

    localparam int PIX_W        = 12;
    localparam int OUT_W        = 20;
    localparam int CFG_W        = 64;
    localparam int CFG_AW       = 3;
    localparam int DIM_W        = 13;
    localparam int SQ_CELLS     = 32;
    localparam int DIV_CELLS    = 31;
    localparam int CORDIC_CELLS = 30;

    typedef enum logic [CFG_AW-1:0] {
        REG_FOCAL       = 3'd0,
        REG_PRINCIPAL   = 3'd1,
        REG_RECT_INV    = 3'd2,
        REG_RECT_CENTER = 3'd3,
        REG_K12         = 3'd4,
        REG_K34         = 3'd5,
        REG_SRC_W       = 3'd6,
        REG_SRC_H       = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] ix;
        logic signed [31:0] iy;
    } norm_pair_t;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] res;
    } sqrt_state_t;

    typedef struct packed {
        logic [62:0] rem_x;
        logic [62:0] rem_y;
        logic [30:0] q_x;
        logic [30:0] q_y;
        logic [31:0] d;
    } div_state_t;

    typedef struct packed {
        logic signed [41:0] x;
        logic signed [41:0] y;
        logic signed [33:0] z;
    } cordic_state_t;

    // Arctangent of 2^-i in Q.30, truncated.
    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] v;
        begin
            case (idx)
                0:  v = 32'h3243F6A8;
                1:  v = 32'h1DAC6705;
                2:  v = 32'h0FADBAFC;
                3:  v = 32'h07F56EA6;
                4:  v = 32'h03FEAB76;
                5:  v = 32'h01FFD55B;
                6:  v = 32'h00FFFAAA;
                7:  v = 32'h007FFF55;
                8:  v = 32'h003FFFEA;
                9:  v = 32'h001FFFFD;
                10: v = 32'h000FFFFF;
                11: v = 32'h0007FFFF;
                12: v = 32'h0003FFFF;
                13: v = 32'h0001FFFF;
                14: v = 32'h0000FFFF;
                15: v = 32'h00007FFF;
                16: v = 32'h00003FFF;
                17: v = 32'h00001FFF;
                18: v = 32'h00000FFF;
                19: v = 32'h000007FF;
                20: v = 32'h000003FF;
                21: v = 32'h000001FF;
                22: v = 32'h000000FF;
                23: v = 32'h0000007F;
                24: v = 32'h0000003F;
                25: v = 32'h0000001F;
                26: v = 32'h0000000F;
                27: v = 32'h00000008;
                28: v = 32'h00000004;
                29: v = 32'h00000002;
                default: v = 32'h00000000;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- hdl/frcm_sqrt_cell.sv -----
module frcm_sqrt_cell #(
    parameter int IDX = 0
) (
    input  logic                  clk,
    input  logic                  en,
    input  frcm_pkg::sqrt_state_t din,
    output frcm_pkg::sqrt_state_t dout
);
    import frcm_pkg::*;

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * IDX);

    logic [63:0] trial;
    sqrt_state_t state_next;
    sqrt_state_t state_reg;

    always_comb
    begin
        trial = din.res + BIT;
        if (din.v >= trial)
        begin
            state_next.v   = din.v - trial;
            state_next.res = (din.res >> 1) + BIT;
        end
        else
        begin
            state_next.v   = din.v;
            state_next.res = din.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign dout = state_reg;

endmodule

// ----- hdl/frcm_div_cell.sv -----
module frcm_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic                 clk,
    input  logic                 en,
    input  frcm_pkg::div_state_t din,
    output frcm_pkg::div_state_t dout
);
    import frcm_pkg::*;

    logic [62:0] dsh;
    div_state_t state_next;
    div_state_t state_reg;

    always_comb
    begin
        dsh        = {31'd0, din.d} << SHIFT;
        state_next = din;
        if (din.rem_x >= dsh)
        begin
            state_next.rem_x = din.rem_x - dsh;
            state_next.q_x   = din.q_x | (31'd1 << SHIFT);
        end
        if (din.rem_y >= dsh)
        begin
            state_next.rem_y = din.rem_y - dsh;
            state_next.q_y   = din.q_y | (31'd1 << SHIFT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign dout = state_reg;

endmodule

// ----- hdl/frcm_cordic_cell.sv -----
module frcm_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                    clk,
    input  logic                    en,
    input  frcm_pkg::cordic_state_t din,
    output frcm_pkg::cordic_state_t dout
);
    import frcm_pkg::*;

    localparam logic signed [33:0] ANG = $signed({2'b00, atan_entry(IDX)});

    logic signed [41:0] xs;
    logic signed [41:0] ys;
    cordic_state_t state_next;
    cordic_state_t state_reg;

    always_comb
    begin
        xs = din.x >>> IDX;
        ys = din.y >>> IDX;
        if (din.y >= 0)
        begin
            state_next.x = din.x + ys;
            state_next.y = din.y - xs;
            state_next.z = din.z + ANG;
        end
        else
        begin
            state_next.x = din.x - ys;
            state_next.y = din.y + xs;
            state_next.z = din.z - ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign dout = state_reg;

endmodule

// ----- hdl/fisheye_rectify_coordinate_map.sv -----
// Maps each rectified pixel to its fisheye source position with the equidistant
// lens model. One pixel is taken per clock and one result leaves per clock. The
// pipeline is made of a 5-stage front end, the 32-cell square root row,
// followed by the 30-cell arctangent row that runs beside the 31-cell divider
// row, and an 11-stage multiply back end. When the output is held off, the
// whole pipeline holds.
// Calibration registers are to be written while no pixels are in flight.
module fisheye_rectify_coordinate_map #(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,  // rect_x[11:0], rect_y[23:12]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [39:0]                   m_axis_tdata,  // src_x[19:0], src_y[39:20]
    output logic                          m_axis_tuser,  // valid_res[0]
    input  logic                          cfg_we,
    input  logic [frcm_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [frcm_pkg::CFG_W-1:0]    cfg_wdata
);
    import frcm_pkg::*;

    localparam int LAT  = 5 + SQ_CELLS + DIV_CELLS + 11;
    localparam int SIDE = SQ_CELLS + DIV_CELLS + 8;
    localparam int LIM  = MAX_DIM - 1;
    localparam logic [14:0] LIM_V = 15'(LIM);
    localparam int SH   = 16 - FRAC_BITS;

    // Configuration registers.
    logic [63:0]      focal_reg, principal_reg, rinv_reg, rcen_reg, k12_reg, k34_reg;
    logic [DIM_W-1:0] srcw_reg, srch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg     <= '0;
            principal_reg <= '0;
            rinv_reg      <= '0;
            rcen_reg      <= '0;
            k12_reg       <= '0;
            k34_reg       <= '0;
            srcw_reg      <= 13'd640;
            srch_reg      <= 13'd480;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_FOCAL:       focal_reg     <= cfg_wdata;
                REG_PRINCIPAL:   principal_reg <= cfg_wdata;
                REG_RECT_INV:    rinv_reg      <= cfg_wdata;
                REG_RECT_CENTER: rcen_reg      <= cfg_wdata;
                REG_K12:         k12_reg       <= cfg_wdata;
                REG_K34:         k34_reg       <= cfg_wdata;
                REG_SRC_W:       srcw_reg      <= cfg_wdata[DIM_W-1:0];
                REG_SRC_H:       srch_reg      <= cfg_wdata[DIM_W-1:0];
                default:         ;
            endcase
        end
    end

    // Pipeline control: every stage moves when the output register is free.
    logic en;
    logic [LAT-1:0] vld_reg;

    assign en            = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // Front end: offset, scale, saturate, square.
    logic [PIX_W-1:0]   px, py;
    logic signed [33:0] dx, dy;
    logic [31:0]        magx_reg, magy_reg;
    logic               negx_reg, negy_reg, negx1_reg, negy1_reg;
    logic [63:0]        prodx_reg, prody_reg;
    logic [30:0]        smagx, smagy;
    logic signed [31:0] ix2_reg, iy2_reg, ix3_reg, iy3_reg;
    logic signed [63:0] sqx_full, sqy_full;
    logic [61:0]        sqx_reg, sqy_reg;
    logic [62:0]        sum_reg;

    always_comb
    begin
        px = ({3'b000, s_axis_tdata[11:0]} > LIM_V) ? LIM_V[PIX_W-1:0] : s_axis_tdata[11:0];
        py = ({3'b000, s_axis_tdata[23:12]} > LIM_V) ? LIM_V[PIX_W-1:0] : s_axis_tdata[23:12];
        dx = $signed({6'd0, px, 16'd0}) - $signed({{2{rcen_reg[31]}}, rcen_reg[31:0]});
        dy = $signed({6'd0, py, 16'd0}) - $signed({{2{rcen_reg[63]}}, rcen_reg[63:32]});
        smagx = (prodx_reg[63:16] > 48'h7FFFFFFF) ? 31'h7FFFFFFF : prodx_reg[46:16];
        smagy = (prody_reg[63:16] > 48'h7FFFFFFF) ? 31'h7FFFFFFF : prody_reg[46:16];
        sqx_full = ix2_reg * ix2_reg;
        sqy_full = iy2_reg * iy2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            negx_reg  <= dx[33];
            negy_reg  <= dy[33];
            magx_reg  <= dx[33] ? 32'(-dx) : dx[31:0];
            magy_reg  <= dy[33] ? 32'(-dy) : dy[31:0];
            prodx_reg <= magx_reg * rinv_reg[31:0];
            prody_reg <= magy_reg * rinv_reg[63:32];
            negx1_reg <= negx_reg;
            negy1_reg <= negy_reg;
            ix2_reg   <= negx1_reg ? -$signed({1'b0, smagx}) : $signed({1'b0, smagx});
            iy2_reg   <= negy1_reg ? -$signed({1'b0, smagy}) : $signed({1'b0, smagy});
            sqx_reg   <= sqx_full[61:0];
            sqy_reg   <= sqy_full[61:0];
            ix3_reg   <= ix2_reg;
            iy3_reg   <= iy2_reg;
            sum_reg   <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        end
    end

    // Normalized point travels beside the cell rows.
    norm_pair_t side_reg [0:SIDE-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= '{ix: ix3_reg, iy: iy3_reg};
            for (int i = 1; i < SIDE; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Square root row.
    sqrt_state_t sq_chain [0:SQ_CELLS];
    assign sq_chain[0] = '{v: {1'b0, sum_reg}, res: 64'd0};

    for (genvar g = 0; g < SQ_CELLS; g++)
    begin : g_sqrt
        frcm_sqrt_cell #(.IDX(g)) u_cell (
            .clk  (clk),
            .en   (en),
            .din  (sq_chain[g]),
            .dout (sq_chain[g+1])
        );
    end

    logic [31:0]        r_val;
    logic signed [31:0] abs_x, abs_y;

    always_comb
    begin
        r_val = sq_chain[SQ_CELLS].res[31:0];
        abs_x = side_reg[SQ_CELLS].ix[31] ? -side_reg[SQ_CELLS].ix : side_reg[SQ_CELLS].ix;
        abs_y = side_reg[SQ_CELLS].iy[31] ? -side_reg[SQ_CELLS].iy : side_reg[SQ_CELLS].iy;
    end

    // Divider row: |i| * 2^30 / r, one quotient bit per cell.
    div_state_t dv_chain [0:DIV_CELLS];
    assign dv_chain[0] = '{rem_x: {2'b00, abs_x[30:0], 30'd0},
                           rem_y: {2'b00, abs_y[30:0], 30'd0},
                           q_x: 31'd0, q_y: 31'd0, d: r_val};

    for (genvar g = 0; g < DIV_CELLS; g++)
    begin : g_div
        frcm_div_cell #(.SHIFT(DIV_CELLS - 1 - g)) u_cell (
            .clk  (clk),
            .en   (en),
            .din  (dv_chain[g]),
            .dout (dv_chain[g+1])
        );
    end

    // Arctangent row in vectoring mode, then a clamp stage.
    cordic_state_t cd_chain [0:CORDIC_CELLS];
    assign cd_chain[0] = '{x: 42'sd1 <<< 30, y: $signed({4'd0, r_val, 6'd0}), z: 34'sd0};

    for (genvar g = 0; g < CORDIC_CELLS; g++)
    begin : g_cordic
        frcm_cordic_cell #(.IDX(g)) u_cell (
            .clk  (clk),
            .en   (en),
            .din  (cd_chain[g]),
            .dout (cd_chain[g+1])
        );
    end

    logic [30:0] theta_reg;
    logic signed [33:0] zf;

    assign zf = cd_chain[CORDIC_CELLS].z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zf < 0)
                theta_reg <= '0;
            else if (zf > 34'sh7FFFFFFF)
                theta_reg <= 31'h7FFFFFFF;
            else
                theta_reg <= zf[30:0];
        end
    end

    // Back end: powers, polynomial, scaling and projection.
    localparam int DOUT = SQ_CELLS + DIV_CELLS;
    div_state_t dq;
    assign dq = dv_chain[DIV_CELLS];

    logic [61:0]        th_sq;
    logic [59:0]        t2_sq;
    logic [61:0]        t42;
    logic [63:0]        t44;
    logic signed [64:0] m1, m2, m3, m4;
    logic signed [43:0] psum;
    logic signed [58:0] tm;
    logic signed [66:0] upx, upy;
    logic signed [61:0] pfx, pfy;

    logic signed [31:0] qx1_reg, qy1_reg, qx2_reg, qy2_reg, qx3_reg, qy3_reg;
    logic signed [31:0] qx4_reg, qy4_reg, qx5_reg, qy5_reg, qx6_reg, qy6_reg;
    logic               rz1_reg, rz2_reg, rz3_reg, rz4_reg, rz5_reg, rz6_reg, rz7_reg;
    logic [30:0]        th1_reg, th2_reg, th3_reg, th4_reg, th5_reg;
    logic [29:0]        t2_reg, t2b_reg, t2c_reg;
    logic [31:0]        t4_reg, t4c_reg;
    logic [33:0]        t6_reg;
    logic [35:0]        t8_reg;
    logic signed [40:0] tr1_reg, tr2_reg, tr3_reg, tr4_reg;
    logic signed [32:0] poly_reg;
    logic signed [34:0] thd_reg;
    logic signed [66:0] upx_reg, upy_reg;
    logic signed [36:0] ux_reg, uy_reg;
    logic signed [61:0] pfx_reg, pfy_reg;
    logic signed [43:0] ox_reg, oy_reg;

    always_comb
    begin
        th_sq = theta_reg * theta_reg;
        t2_sq = t2_reg * t2_reg;
        t42   = t4_reg * t2b_reg;
        t44   = t4_reg * t4_reg;
        m1 = $signed(k12_reg[31:0])  * $signed({7'd0, t2c_reg[29:4]});
        m2 = $signed(k12_reg[63:32]) * $signed({5'd0, t4c_reg[31:4]});
        m3 = $signed(k34_reg[31:0])  * $signed({3'd0, t6_reg[33:4]});
        m4 = $signed(k34_reg[63:32]) * $signed({1'b0, t8_reg[35:4]});
        psum = 44'sd268435456 + 44'(tr1_reg) + 44'(tr2_reg) + 44'(tr3_reg) + 44'(tr4_reg);
        tm   = $signed({1'b0, th5_reg[30:6]}) * poly_reg;
        upx  = qx6_reg * thd_reg;
        upy  = qy6_reg * thd_reg;
        pfx  = $signed({1'b0, focal_reg[31:0]})  * $signed(ux_reg[36:8]);
        pfy  = $signed({1'b0, focal_reg[63:32]}) * $signed(uy_reg[36:8]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx1_reg <= side_reg[DOUT].ix[31] ? -$signed({1'b0, dq.q_x}) : $signed({1'b0, dq.q_x});
            qy1_reg <= side_reg[DOUT].iy[31] ? -$signed({1'b0, dq.q_y}) : $signed({1'b0, dq.q_y});
            rz1_reg <= (dq.d == 32'd0);
            th1_reg <= theta_reg;
            t2_reg  <= th_sq[61:32];

            qx2_reg <= qx1_reg;
            qy2_reg <= qy1_reg;
            rz2_reg <= rz1_reg;
            th2_reg <= th1_reg;
            t2b_reg <= t2_reg;
            t4_reg  <= t2_sq[59:28];

            qx3_reg <= qx2_reg;
            qy3_reg <= qy2_reg;
            rz3_reg <= rz2_reg;
            th3_reg <= th2_reg;
            t2c_reg <= t2b_reg;
            t4c_reg <= t4_reg;
            t6_reg  <= t42[61:28];
            t8_reg  <= t44[63:28];

            qx4_reg <= qx3_reg;
            qy4_reg <= qy3_reg;
            rz4_reg <= rz3_reg;
            th4_reg <= th3_reg;
            tr1_reg <= m1[64:24];
            tr2_reg <= m2[64:24];
            tr3_reg <= m3[64:24];
            tr4_reg <= m4[64:24];

            qx5_reg <= qx4_reg;
            qy5_reg <= qy4_reg;
            rz5_reg <= rz4_reg;
            th5_reg <= th4_reg;
            if (psum > 44'sh80000000)
                poly_reg <= 33'sh080000000;
            else if (psum < -44'sh80000000)
                poly_reg <= -33'sh080000000;
            else
                poly_reg <= psum[32:0];

            qx6_reg <= qx5_reg;
            qy6_reg <= qy5_reg;
            rz6_reg <= rz5_reg;
            thd_reg <= tm[58:24];

            rz7_reg <= rz6_reg;
            upx_reg <= upx;
            upy_reg <= upy;

            // At zero radius the scale is one: u is the normalized point in Q.28.
            ux_reg <= rz7_reg ? 37'({side_reg[SIDE-1].ix, 4'd0}) : upx_reg[66:30];
            uy_reg <= rz7_reg ? 37'({side_reg[SIDE-1].iy, 4'd0}) : upy_reg[66:30];

            pfx_reg <= pfx;
            pfy_reg <= pfy;

            ox_reg <= 44'($signed(pfx_reg[61:20])) + $signed({12'd0, principal_reg[31:0]});
            oy_reg <= 44'($signed(pfy_reg[61:20])) + $signed({12'd0, principal_reg[63:32]});
        end
    end

    // Border test and output register.
    logic signed [43:0] wl, hl;
    logic [43:0]        ex, ey;
    logic               ok;
    logic [OUT_W-1:0]   srcx_reg, srcy_reg;
    logic               okr_reg;

    always_comb
    begin
        wl = 44'($signed({1'b0, srcw_reg}) - 14'sd1) <<< 16;
        hl = 44'($signed({1'b0, srch_reg}) - 14'sd1) <<< 16;
        ok = (ox_reg > 0) && (oy_reg > 0) && (ox_reg < wl) && (oy_reg < hl);
        ex = 44'(ox_reg) >> SH;
        ey = 44'(oy_reg) >> SH;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            okr_reg  <= ok;
            srcx_reg <= !ok ? '0 : ((ex > 44'hFFFFF) ? 20'hFFFFF : ex[OUT_W-1:0]);
            srcy_reg <= !ok ? '0 : ((ey > 44'hFFFFF) ? 20'hFFFFF : ey[OUT_W-1:0]);
        end
    end

    assign m_axis_tdata = {srcy_reg, srcx_reg};
    assign m_axis_tuser = okr_reg;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 40'd0))
        else $error("invalid point carries nonzero coordinates");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> vld_reg[0])
        else $error("accepted beat did not enter the pipeline");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input held off without a stalled output");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_reg))
        else $error("pipeline moved while output stalled");
`endif

endmodule

// ----- bench/fisheye_rectify_coordinate_map_test.sv -----
`timescale 1ns / 1ps

module fisheye_rectify_coordinate_map_test;
    import frcm_pkg::*;

    typedef struct packed {
        logic [19:0] sx;
        logic [19:0] sy;
        logic        ok;
    } src_point_t;

    // Arctangent of 2^-i in Q.30, truncated.
    localparam longint ATAN_STEP [30] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
    };

    class lens_scoreboard;
        logic [63:0] cal [8];
        src_point_t  pending [$];
        int          errors;

        function new();
            foreach (cal[i]) cal[i] = '0;
            cal[REG_SRC_W] = 64'd640;
            cal[REG_SRC_H] = 64'd480;
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [63:0] val);
            if (idx == REG_SRC_W || idx == REG_SRC_H)
                val &= 64'h1FFF;
            cal[idx] = val;
        endfunction

        static function longint floor_shift(longint v, int s);
            return v >>> s;
        endfunction

        static function longint sext32(logic [31:0] v);
            return longint'(signed'(v));
        endfunction

        static function longint normalize(longint pix, longint ctr, longint inv);
            longint d;
            longint mag;
            longint p;
            d = (pix << 16) - ctr;
            mag = d < 0 ? -d : d;
            p = longint'((64'(mag) * 64'(inv)) >> 16);
            if (p > 64'h7FFFFFFF || p < 0)
                p = 64'h7FFFFFFF;
            return d < 0 ? -p : p;
        endfunction

        static function longint unsigned root(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        static function longint arctan(longint r);
            longint x;
            longint y;
            longint z;
            longint xs;
            longint ys;
            x = 64'sd1 << 30;
            y = r << 6;
            z = 0;
            for (int i = 0; i < 30; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x += ys; y -= xs; z += ATAN_STEP[i];
                end
                else
                begin
                    x -= ys; y += xs; z -= ATAN_STEP[i];
                end
            end
            if (z < 0) z = 0;
            if (z > 64'sh7FFFFFFF) z = 64'sh7FFFFFFF;
            return z;
        endfunction

        static function longint project(longint u, longint f, longint c);
            return ((f * (u >>> 8)) >>> 20) + c;
        endfunction

        function src_point_t map_point(logic [11:0] px, logic [11:0] py);
            longint ix, iy, th, poly, thd, ux, uy, ox, oy, wl, hl;
            longint unsigned r, t2, t4, t6, t8;
            src_point_t p;
            ix = normalize(px, sext32(cal[REG_RECT_CENTER][31:0]),
                           cal[REG_RECT_INV][31:0]);
            iy = normalize(py, sext32(cal[REG_RECT_CENTER][63:32]),
                           cal[REG_RECT_INV][63:32]);
            r = root(64'(ix * ix) + 64'(iy * iy));
            if (r == 0)
            begin
                ux = ix * 16;
                uy = iy * 16;
            end
            else
            begin
                th = arctan(longint'(r));
                t2 = (64'(th) * 64'(th)) >> 32;
                t4 = (t2 * t2) >> 28;
                t6 = (t4 * t2) >> 28;
                t8 = (t4 * t4) >> 28;
                poly = (64'sd1 << 28)
                     + ((sext32(cal[REG_K12][31:0]) * longint'(t2 >> 4)) >>> 24)
                     + ((sext32(cal[REG_K12][63:32]) * longint'(t4 >> 4)) >>> 24)
                     + ((sext32(cal[REG_K34][31:0]) * longint'(t6 >> 4)) >>> 24)
                     + ((sext32(cal[REG_K34][63:32]) * longint'(t8 >> 4)) >>> 24);
                if (poly > (64'sd1 << 31)) poly = 64'sd1 << 31;
                if (poly < -(64'sd1 << 31)) poly = -(64'sd1 << 31);
                thd = ((th >>> 6) * poly) >>> 24;
                ux = (((ix * (64'sd1 << 30)) / longint'(r)) * thd) >>> 30;
                uy = (((iy * (64'sd1 << 30)) / longint'(r)) * thd) >>> 30;
            end
            ox = project(ux, cal[REG_FOCAL][31:0], cal[REG_PRINCIPAL][31:0]);
            oy = project(uy, cal[REG_FOCAL][63:32], cal[REG_PRINCIPAL][63:32]);
            wl = (longint'(cal[REG_SRC_W]) - 1) * 65536;
            hl = (longint'(cal[REG_SRC_H]) - 1) * 65536;
            p.ok = ox > 0 && oy > 0 && ox < wl && oy < hl;
            p.sx = '0;
            p.sy = '0;
            if (p.ok)
            begin
                p.sx = (ox >>> 8) > 64'hFFFFF ? 20'hFFFFF : 20'(ox >>> 8);
                p.sy = (oy >>> 8) > 64'hFFFFF ? 20'hFFFFF : 20'(oy >>> 8);
            end
            return p;
        endfunction

        function void note_pixel(logic [23:0] beat);
            pending.push_back(map_point(beat[11:0], beat[23:12]));
        endfunction

        function void check_point(logic [39:0] data, logic flag);
            src_point_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h valid %b", $time, data, flag);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[19:0] !== e.sx)
            begin
                $display("%0t: src_x expected %h actual %h", $time, e.sx, data[19:0]);
                errors++;
            end
            if (data[39:20] !== e.sy)
            begin
                $display("%0t: src_y expected %h actual %h", $time, e.sy, data[39:20]);
                errors++;
            end
            if (flag !== e.ok)
            begin
                $display("%0t: valid_res expected %b actual %b", $time, e.ok, flag);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    lens_scoreboard sb = new();
    longint cycles = 0;
    bit     hold_off = 1'b0;
    bit     drain_done = 1'b0;

    always #6 clk = ~clk;

    fisheye_rectify_coordinate_map uut (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("** fisheye_rectify_coordinate_map: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_point(m_axis_tdata, m_axis_tuser);

    // Receiver: random stalls, a quiet spell, or a long forced hold-off.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                m_axis_tready <= 1'b0;
            else
            begin
                n = $urandom_range(0, 99);
                m_axis_tready <= (n < 70) || drain_done;
                if (n < 2)
                    repeat ($urandom_range(20, 120)) @(posedge clk);
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // The valid line stays up between beats unless a gap is taken.
    task automatic send_pixel(logic [11:0] px, logic [11:0] py, bit gaps);
        int g;
        if (gaps)
        begin
            g = $urandom_range(0, 99);
            if (g < 22)
                s_axis_tvalid <= 1'b0;
            if (g < 20)
                repeat ($urandom_range(1, 3)) @(posedge clk);
            else if (g < 22)
                repeat ($urandom_range(20, 80)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {py, px};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_pixel({py, px});
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // A camera centered on the image, with the given focal length, scale and distortion.
    task automatic set_camera(int w, int h, logic [31:0] f, logic [31:0] inv,
                              logic [31:0] k1, logic [31:0] k2,
                              logic [31:0] k3, logic [31:0] k4);
        write_reg(REG_FOCAL, {f, f});
        write_reg(REG_PRINCIPAL, {32'(h) << 15, 32'(w) << 15});
        write_reg(REG_RECT_INV, {inv, inv});
        write_reg(REG_RECT_CENTER, {32'(h) << 15, 32'(w) << 15});
        write_reg(REG_K12, {k2, k1});
        write_reg(REG_K34, {k4, k3});
        write_reg(REG_SRC_W, 64'(w));
        write_reg(REG_SRC_H, 64'(h));
    endtask

    task automatic random_phase(int n, int w, int h);
        logic [11:0] px, py;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                px = 12'($urandom_range(0, w > 4095 ? 4095 : w));
                py = 12'($urandom_range(0, h > 4095 ? 4095 : h));
            end
            else
            begin
                px = 12'($urandom);
                py = 12'($urandom);
            end
            send_pixel(px, py, i % 100 > 20);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: all-zero calibration maps every pixel to the origin.
        send_pixel(12'd0, 12'd0, 0);
        send_pixel(12'hFFF, 12'hFFF, 0);
        wait_idle();

        set_camera(640, 480, 32'd300 << 16, 32'h0000EEEF, 32'hFF000000,
                   32'h00400000, 32'h00000000, 32'hFFF00000);
        // Directed: center (zero radius), corners, edges and field extremes.
        send_pixel(12'd320, 12'd240, 0);
        send_pixel(12'd0, 12'd0, 0);
        send_pixel(12'd639, 12'd479, 0);
        send_pixel(12'd0, 12'd479, 0);
        send_pixel(12'd639, 12'd0, 0);
        send_pixel(12'hFFF, 12'd0, 0);
        send_pixel(12'd0, 12'hFFF, 0);
        send_pixel(12'hAAA, 12'h555, 0);
        send_pixel(12'h555, 12'hAAA, 0);
        send_pixel(12'd321, 12'd240, 0);
        wait_idle();

        // Pressure: receiver holds off while the sender keeps offering.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
        join_none
        random_phase(150, 640, 480);
        wait_idle();

        // Huge coefficients force polynomial saturation; tiny image invalidates.
        set_camera(2, 2, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_pixel(12'd1, 12'd1, 0);
        send_pixel(12'd0, 12'd0, 0);
        send_pixel(12'hFFF, 12'hFFF, 0);
        wait_idle();
        write_reg(REG_SRC_W, 64'd0);
        write_reg(REG_SRC_H, 64'h1FFF);
        wait_idle();
        send_pixel(12'd5, 12'd5, 0);
        wait_idle();

        set_camera(4096, 4096, 32'd2000 << 16, 32'h00000830, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h80000000);
        write_reg(REG_PRINCIPAL, 64'hFFFFFFFF_FFFFFFFF);
        random_phase(150, 4096, 4096);
        wait_idle();

        set_camera(1280, 720, 32'd500 << 16, 32'h00008312, 32'h01000000,
                   32'hFF800000, 32'h00200000, 32'h00000000);
        random_phase(200, 1280, 720);
        wait_idle();

        // Fully random calibration words.
        for (int k = 0; k < 3; k++)
        begin
            write_reg(REG_FOCAL, {$urandom, $urandom});
            write_reg(REG_PRINCIPAL, {$urandom, $urandom});
            write_reg(REG_RECT_INV, {$urandom, $urandom} >> $urandom_range(0, 40));
            write_reg(REG_RECT_CENTER, {$urandom, $urandom});
            write_reg(REG_K12, {$urandom, $urandom});
            write_reg(REG_K34, {$urandom, $urandom});
            write_reg(REG_SRC_W, 64'($urandom_range(0, 8191)));
            write_reg(REG_SRC_H, 64'($urandom_range(0, 8191)));
            random_phase(80, 4095, 4095);
            wait_idle();
        end

        drain_done = 1'b1;
        wait_idle();
        if (sb.errors == 0)
            $display("** fisheye_rectify_coordinate_map: PASSED **");
        else
            $display("** fisheye_rectify_coordinate_map: FAILED **");
        $finish;
    end
endmodule
